// ----- src/mnbt_pkg.sv -----
// shared types and constants for the multitone nibble burst transmitter
// no dependencies; imported by every module of the block

package mnbt_pkg;

  localparam int unsigned ToneCount   = 5;
  localparam int unsigned DataTones   = 4;
  localparam int unsigned ReloadW     = 16;
  localparam int unsigned PeriodW     = 8;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 16;

  // register reset values
  localparam logic [ReloadW-1:0] RefReloadRst  = 16'h0258;
  localparam logic [ReloadW-1:0] Bit0ReloadRst = 16'h0233;
  localparam logic [ReloadW-1:0] Bit1ReloadRst = 16'h0211;
  localparam logic [ReloadW-1:0] Bit2ReloadRst = 16'h01F4;
  localparam logic [ReloadW-1:0] Bit3ReloadRst = 16'h01DA;
  localparam logic [PeriodW-1:0] BurstRst      = 8'd16;
  localparam logic [PeriodW-1:0] SilenceRst    = 8'd32;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_REF_RELOAD  = 3'd0,
    CFG_BIT0_RELOAD = 3'd1,
    CFG_BIT1_RELOAD = 3'd2,
    CFG_BIT2_RELOAD = 3'd3,
    CFG_BIT3_RELOAD = 3'd4,
    CFG_PIN_GROUP   = 3'd5,
    CFG_BURST       = 3'd6,
    CFG_SILENCE     = 3'd7
  } mnbt_cfg_idx_t;

  // input kind carried on tuser
  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_START = 1'b1
  } mnbt_func_t;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [ToneCount-1:0][ReloadW-1:0] reload;
    logic                              pin_group;
    logic [PeriodW-1:0]                burst_periods;
    logic [PeriodW-1:0]                silence_periods;
  } mnbt_cfg_t;

  // one result item
  typedef struct packed {
    logic [ToneCount-1:0] group1_lines;
    logic [ToneCount-1:0] group0_lines;
    logic                 busy;
    logic                 done;
  } mnbt_res_t;

endpackage

// ----- src/multitone_nibble_burst_transmitter_unit.sv -----
// datapath: the input register holds an accepted item, then the sequencer logic
//   writes its result into the output register, which drives out_tvalid
// throughput: one item per cycle; the output register stalls the input side only
//   while a result waits and the input register is full
// reset: synchronous active-low rst_n clears control and dividers, loads config defaults
// top level: config registers, input register, sequencer, output register; uses mnbt_pkg

module multitone_nibble_burst_transmitter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mnbt_pkg::InDataW-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                          in_tuser,   // [0] func
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mnbt_pkg::OutDataW-1:0] out_tdata,  // [4:0] group0_lines,
                                                    // [9:5] group1_lines,
                                                    // [10] busy_res, [11] done_res,
                                                    // [15:12] zero
  // configuration write port
  input  logic                          cfg_we,
  input  logic [mnbt_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [mnbt_pkg::CfgDataW-1:0] cfg_wdata
);
  import mnbt_pkg::*;

  mnbt_cfg_t          cfg_r;
  logic               s1_valid_r;
  logic               s1_func_r;
  logic [InDataW-1:0] s1_byte_r;
  logic               out_valid_r;
  mnbt_res_t          out_res_r;
  mnbt_res_t          res;
  logic               adv;
  logic               fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reload[0]       <= RefReloadRst;
      cfg_r.reload[1]       <= Bit0ReloadRst;
      cfg_r.reload[2]       <= Bit1ReloadRst;
      cfg_r.reload[3]       <= Bit2ReloadRst;
      cfg_r.reload[4]       <= Bit3ReloadRst;
      cfg_r.pin_group       <= 1'b0;
      cfg_r.burst_periods   <= BurstRst;
      cfg_r.silence_periods <= SilenceRst;
    end else if (cfg_we) begin
      unique case (mnbt_cfg_idx_t'(cfg_addr))
        CFG_REF_RELOAD:  cfg_r.reload[0]       <= cfg_wdata;
        CFG_BIT0_RELOAD: cfg_r.reload[1]       <= cfg_wdata;
        CFG_BIT1_RELOAD: cfg_r.reload[2]       <= cfg_wdata;
        CFG_BIT2_RELOAD: cfg_r.reload[3]       <= cfg_wdata;
        CFG_BIT3_RELOAD: cfg_r.reload[4]       <= cfg_wdata;
        CFG_PIN_GROUP:   cfg_r.pin_group       <= cfg_wdata[0];
        CFG_BURST:       cfg_r.burst_periods   <= cfg_wdata[PeriodW-1:0];
        CFG_SILENCE:     cfg_r.silence_periods <= cfg_wdata[PeriodW-1:0];
        default:         cfg_r                 <= cfg_r;
      endcase
    end
  end

  // pipeline advance control
  assign adv       = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_func_r <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  mnbt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .func      (s1_func_r),
    .data_byte (s1_byte_r),
    .cfg       (cfg_r),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.done, out_res_r.busy,
                       out_res_r.group1_lines, out_res_r.group0_lines};

endmodule

// ----- src/mnbt_div.sv -----
// one reload divider: counts 0..reload, then wraps and flags overflow
// depends on mnbt_pkg for widths

module mnbt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        clr,
  input  logic [mnbt_pkg::ReloadW-1:0] reload,
  output logic                        wrap
);
  import mnbt_pkg::*;

  logic [ReloadW-1:0] cnt_r;
  logic [ReloadW-1:0] cnt_nxt;

  // wrap when at or above reload
  assign wrap = (cnt_r >= reload);

  // clear has priority over a step in the same transfer
  always_comb begin
    cnt_nxt = cnt_r;
    if (clr) begin
      cnt_nxt = '0;
    end else if (adv) begin
      cnt_nxt = wrap ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/mnbt_seq.sv -----
// burst sequencer: five dividers, tone levels, burst and silence counting
// depends on mnbt_pkg and mnbt_div

module mnbt_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic                        func,
  input  logic [mnbt_pkg::InDataW-1:0] data_byte,
  input  mnbt_pkg::mnbt_cfg_t         cfg,
  output mnbt_pkg::mnbt_res_t         res
);
  import mnbt_pkg::*;

  logic [ToneCount-1:0] lev_r, lev_nxt;
  logic [DataTones-1:0] en_r, en_nxt;
  logic [PeriodW-1:0]   bc_r, bc_nxt;
  logic [PeriodW-1:0]   sc_r, sc_nxt;
  logic [PeriodW-1:0]   sc_tmp;
  logic                 nib_r, nib_nxt;
  logic                 inb_r, inb_nxt;
  logic [InDataW-1:0]   held_r, held_nxt;
  logic                 run_r, run_nxt;
  logic                 fin_r, fin_nxt;
  logic [DataTones-1:0] nibble;

  logic [ToneCount-1:0] wrap;
  logic [ToneCount-1:0] adv;
  logic                 ref_clr;
  logic                 dat_clr;

  // reference divider
  mnbt_div u_div_ref (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv[0]),
    .clr    (ref_clr),
    .reload (cfg.reload[0]),
    .wrap   (wrap[0])
  );

  // data tone dividers
  for (genvar g = 1; g < ToneCount; g++) begin : g_dat
    mnbt_div u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv[g]),
      .clr    (dat_clr),
      .reload (cfg.reload[g]),
      .wrap   (wrap[g])
    );
  end

  assign nibble = nib_r ? held_r[InDataW-1:DataTones] : held_r[DataTones-1:0];

  // next state for one transfer
  always_comb begin
    lev_nxt  = lev_r;
    en_nxt   = en_r;
    bc_nxt   = bc_r;
    sc_nxt   = sc_r;
    sc_tmp   = sc_r;
    nib_nxt  = nib_r;
    inb_nxt  = inb_r;
    held_nxt = held_r;
    run_nxt  = run_r;
    fin_nxt  = fin_r;
    adv      = '0;
    ref_clr  = 1'b0;
    dat_clr  = 1'b0;
    if (fire) begin
      if (func == FUNC_START) begin
        // start is ignored while sending
        if (!run_r) begin
          held_nxt = data_byte;
          lev_nxt  = '0;
          en_nxt   = '0;
          bc_nxt   = '0;
          sc_nxt   = '0;
          nib_nxt  = 1'b0;
          inb_nxt  = 1'b0;
          fin_nxt  = 1'b0;
          run_nxt  = 1'b1;
          ref_clr  = 1'b1;
          dat_clr  = 1'b1;
        end
      end else if (run_r) begin
        adv = {en_r, 1'b1};
        // data tones toggle on their own overflow
        for (int k = 1; k < ToneCount; k++) begin
          if (en_r[k-1] && wrap[k]) begin
            lev_nxt[k] = ~lev_r[k];
          end
        end
        // reference overflow event
        if (wrap[0]) begin
          if (bc_r < cfg.burst_periods) begin
            if (bc_r == '0) begin
              en_nxt  = en_r | nibble;
              inb_nxt = 1'b1;
            end
            lev_nxt[0] = ~lev_r[0];
            if (lev_r[0]) begin
              bc_nxt = bc_r + 1'b1;
            end
          end else begin
            // burst end: silence all lines, restart data dividers
            if (inb_r) begin
              inb_nxt = 1'b0;
              sc_tmp  = '0;
              en_nxt  = '0;
              lev_nxt = '0;
              dat_clr = 1'b1;
            end
            if (sc_tmp < cfg.silence_periods) begin
              sc_nxt = sc_tmp + 1'b1;
            end else begin
              bc_nxt = '0;
              sc_nxt = '0;
              if (nib_r) begin
                nib_nxt = 1'b0;
                run_nxt = 1'b0;
                fin_nxt = 1'b1;
              end else begin
                nib_nxt = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lev_r  <= '0;
      en_r   <= '0;
      bc_r   <= '0;
      sc_r   <= '0;
      nib_r  <= 1'b0;
      inb_r  <= 1'b0;
      held_r <= '0;
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      lev_r  <= lev_nxt;
      en_r   <= en_nxt;
      bc_r   <= bc_nxt;
      sc_r   <= sc_nxt;
      nib_r  <= nib_nxt;
      inb_r  <= inb_nxt;
      held_r <= held_nxt;
      run_r  <= run_nxt;
      fin_r  <= fin_nxt;
    end
  end

  // result from the updated state
  always_comb begin
    res.group0_lines = cfg.pin_group ? '0 : lev_nxt;
    res.group1_lines = cfg.pin_group ? lev_nxt : '0;
    res.busy         = run_nxt;
    res.done         = fin_nxt;
  end

endmodule

// ----- src/mnbt_chk.sv -----
// port-level checks for the transmitter, bound to the top level
// depends on mnbt_pkg for port widths

module mnbt_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [mnbt_pkg::OutDataW-1:0] out_tdata
);
  import mnbt_pkg::*;

  // busy and done never show together
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[10] && out_tdata[11]))
    else $error("busy and done both set");

  // at most one line set carries tones
  a_one_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] == 5'd0 || out_tdata[9:5] == 5'd0))
    else $error("both line sets driven");

  // padding bits above the result fields stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:12] == 4'd0))
    else $error("padding bits set");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind multitone_nibble_burst_transmitter_unit mnbt_chk u_mnbt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/tone_line_checker.sv -----
`timescale 1ns / 100ps
// line checker for the multitone nibble burst transmitter: tracks the tone
// state from input and config transfers and compares every result transfer
// depends on mnbt_pkg for the func and config register codes

module tone_line_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [mnbt_pkg::InDataW-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                          in_tuser,   // [0] func
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [mnbt_pkg::OutDataW-1:0] out_tdata,  // [4:0] group0, [9:5] group1,
                                                    // [10] busy, [11] done
  input  logic                          cfg_we,
  input  logic [mnbt_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [mnbt_pkg::CfgDataW-1:0] cfg_wdata,
  output int                            mismatch_count,
  output int                            pending
);
  import mnbt_pkg::*;

  // result word as it sits on out_tdata
  typedef struct packed {
    logic [3:0] pad;
    logic       done;
    logic       busy;
    logic [4:0] group1;
    logic [4:0] group0;
  } line_word_t;

  line_word_t lines_q[$];

  // register copy
  logic [15:0] reload_val [5];
  logic        pin_sel;
  logic [7:0]  burst_len;
  logic [7:0]  silence_len;

  // transmitter state
  logic [15:0] div_cnt [5];
  logic [4:0]  level;
  logic [3:0]  tone_en;
  logic [7:0]  burst_cnt;
  logic [7:0]  silence_cnt;
  logic        high_nibble;
  logic        bursting;
  logic [7:0]  byte_hold;
  logic        sending;
  logic        sent;

  function automatic void clear_transmitter();
    for (int k = 0; k < 5; k++) div_cnt[k] = '0;
    level       = '0;
    tone_en     = '0;
    burst_cnt   = '0;
    silence_cnt = '0;
    high_nibble = 1'b0;
    bursting    = 1'b0;
  endfunction

  function automatic void load_defaults();
    reload_val[0] = 16'h0258;
    reload_val[1] = 16'h0233;
    reload_val[2] = 16'h0211;
    reload_val[3] = 16'h01F4;
    reload_val[4] = 16'h01DA;
    pin_sel       = 1'b0;
    burst_len     = 8'd16;
    silence_len   = 8'd32;
    clear_transmitter();
    byte_hold = '0;
    sending   = 1'b0;
    sent      = 1'b0;
  endfunction

  function automatic void write_reg(input mnbt_cfg_idx_t idx, input logic [15:0] val);
    case (idx)
      CFG_REF_RELOAD:  reload_val[0] = val;
      CFG_BIT0_RELOAD: reload_val[1] = val;
      CFG_BIT1_RELOAD: reload_val[2] = val;
      CFG_BIT2_RELOAD: reload_val[3] = val;
      CFG_BIT3_RELOAD: reload_val[4] = val;
      CFG_PIN_GROUP:   pin_sel       = val[0];
      CFG_BURST:       burst_len     = val[7:0];
      CFG_SILENCE:     silence_len   = val[7:0];
      default: ;
    endcase
  endfunction

  // divider step, returns 1 on wrap
  function automatic logic wrap_divider(input int k);
    if (div_cnt[k] >= reload_val[k]) begin
      div_cnt[k] = '0;
      return 1'b1;
    end
    div_cnt[k] = div_cnt[k] + 16'd1;
    return 1'b0;
  endfunction

  // one overflow of the reference divider
  function automatic void reference_overflow();
    if (burst_cnt < burst_len) begin
      if (burst_cnt == 8'd0) begin
        tone_en  = tone_en | (high_nibble ? byte_hold[7:4] : byte_hold[3:0]);
        bursting = 1'b1;
      end
      if (!level[0]) begin
        level[0] = 1'b1;
      end else begin
        level[0]  = 1'b0;
        burst_cnt = burst_cnt + 8'd1;
      end
      return;
    end
    // burst over: silence all lines and park the data dividers
    if (bursting) begin
      bursting    = 1'b0;
      silence_cnt = '0;
      tone_en     = '0;
      level       = '0;
      for (int k = 1; k < 5; k++) div_cnt[k] = '0;
    end
    if (silence_cnt < silence_len) begin
      silence_cnt = silence_cnt + 8'd1;
      return;
    end
    burst_cnt   = '0;
    silence_cnt = '0;
    if (high_nibble) begin
      high_nibble = 1'b0;
      sending     = 1'b0;
      sent        = 1'b1;
    end else begin
      high_nibble = 1'b1;
    end
  endfunction

  // apply one input transfer and return the line word it should produce
  function automatic line_word_t advance_transmitter(input mnbt_func_t fn,
                                                     input logic [7:0] data);
    line_word_t w;
    logic       ref_wrap;
    if (fn == FUNC_START) begin
      if (!sending) begin
        clear_transmitter();
        byte_hold = data;
        sent      = 1'b0;
        sending   = 1'b1;
      end
    end else if (sending) begin
      ref_wrap = wrap_divider(0);
      for (int k = 1; k < 5; k++) begin
        if (tone_en[k-1] && wrap_divider(k)) level[k] = ~level[k];
      end
      if (ref_wrap) reference_overflow();
    end
    w.pad    = '0;
    w.done   = sent;
    w.busy   = sending;
    w.group0 = pin_sel ? 5'd0 : level;
    w.group1 = pin_sel ? level : 5'd0;
    return w;
  endfunction

  function automatic void check_field(input string name, input logic [4:0] want,
                                      input logic [4:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // watch all three ports on the rising edge
  always @(posedge clk) begin : watch
    line_word_t want;
    line_word_t got;
    if (!rst_n) begin
      load_defaults();
      lines_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) write_reg(mnbt_cfg_idx_t'(cfg_addr), cfg_wdata);
      if (in_tvalid && in_tready)
        lines_q.push_back(advance_transmitter(mnbt_func_t'(in_tuser), in_tdata));
      if (out_tvalid && out_tready) begin
        got = line_word_t'(out_tdata);
        if (lines_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transfer with none expected, expected none, actual %h",
                   $time, out_tdata);
        end else begin
          want = lines_q.pop_front();
          check_field("group0_lines", want.group0, got.group0);
          check_field("group1_lines", want.group1, got.group1);
          check_field("busy", {4'd0, want.busy}, {4'd0, got.busy});
          check_field("done", {4'd0, want.done}, {4'd0, got.done});
          check_field("pad", {1'b0, want.pad}, {1'b0, got.pad});
        end
      end
    end
    pending = lines_q.size();
  end

endmodule

// ----- tb/tb_multitone_nibble_burst_transmitter_unit.sv -----
`timescale 1ns / 100ps
// top of the multitone nibble burst transmitter bench: clock, reset, stimulus,
// config programming and verdict; checking lives in tone_line_checker
// depends on mnbt_pkg, tone_line_checker and the transmitter unit

module tb_multitone_nibble_burst_transmitter_unit;
  import mnbt_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomPhases  = 9;
  localparam int PhaseItems    = 216;
  localparam int StartPct      = 3;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [InDataW-1:0]   in_tdata   = '0;  // [7:0] data_byte
  logic                 in_tuser   = 1'b0;  // [0] func
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutDataW-1:0]  out_tdata;  // [4:0] group0, [9:5] group1, [10] busy, [11] done
  logic                 cfg_we     = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr   = '0;
  logic [CfgDataW-1:0]  cfg_wdata  = '0;

  int          mismatch_count;
  int          pending;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          quiet_cycles;
  logic [15:0] reg_plan [8];

  multitone_nibble_burst_transmitter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  tone_line_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // watchdog on cycles without any transfer
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_multitone_nibble_burst_transmitter_unit: done, errors");
    $finish;
  end

  // one input transfer, entered and left at a falling edge
  task automatic drive_item(input mnbt_func_t fn, input logic [7:0] data);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic tick_for(input int n);
    for (int i = 0; i < n; i++) drive_item(FUNC_TICK, 8'($urandom_range(0, 255)));
  endtask

  // let every result drain before touching the registers
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // write all eight registers from reg_plan, one per cycle
  task automatic program_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= mnbt_cfg_idx_t'(i);
      cfg_wdata <= reg_plan[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic plan_phase(input int p);
    reg_plan[CFG_REF_RELOAD] = 16'($urandom_range(0, 4));
    for (int k = 0; k < 4; k++)
      reg_plan[int'(CFG_BIT0_RELOAD) + k] = 16'($urandom_range(0, 9));
    reg_plan[CFG_PIN_GROUP] = 16'($urandom_range(0, 1));
    reg_plan[CFG_BURST]     = 16'($urandom_range(1, 4));
    reg_plan[CFG_SILENCE]   = 16'($urandom_range(0, 4));
    case (p)
      // longest bursts and silences
      2: begin
        reg_plan[CFG_REF_RELOAD] = 16'd0;
        reg_plan[CFG_BURST]      = 16'd255;
        reg_plan[CFG_SILENCE]    = 16'd255;
      end
      // slowest dividers, next phase lowers them under the running count
      4: begin
        for (int k = 0; k < 5; k++) reg_plan[k] = 16'hFFFF;
        reg_plan[CFG_BURST]   = 16'd1;
        reg_plan[CFG_SILENCE] = 16'd1;
      end
      // no tones at all, each nibble ends on its first event
      6: begin
        reg_plan[CFG_REF_RELOAD] = 16'd0;
        reg_plan[CFG_BURST]      = 16'd0;
        reg_plan[CFG_SILENCE]    = 16'd0;
      end
      default: ;
    endcase
  endtask

  // main sequence
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    tx_idle_pct = 18;
    rx_idle_pct = 87;

    // reset config: tick while idle, start, start while busy, a few ticks
    drive_item(FUNC_TICK, 8'h00);
    drive_item(FUNC_START, 8'hFF);
    drive_item(FUNC_START, 8'h00);
    tick_for(2);
    drain();

    // reload zero under a running count, pin group moved mid-byte, no silence
    reg_plan[CFG_REF_RELOAD]  = 16'd0;
    reg_plan[CFG_BIT0_RELOAD] = 16'd0;
    reg_plan[CFG_BIT1_RELOAD] = 16'd1;
    reg_plan[CFG_BIT2_RELOAD] = 16'd2;
    reg_plan[CFG_BIT3_RELOAD] = 16'hFFFF;
    reg_plan[CFG_PIN_GROUP]   = 16'd1;
    reg_plan[CFG_BURST]       = 16'd1;
    reg_plan[CFG_SILENCE]     = 16'd0;
    program_regs();
    tick_for(6);
    drive_item(FUNC_START, 8'h00);
    tick_for(6);
    drain();

    // zero burst length: silence only
    reg_plan[CFG_PIN_GROUP] = 16'd0;
    reg_plan[CFG_BURST]     = 16'd0;
    reg_plan[CFG_SILENCE]   = 16'd2;
    program_regs();
    drive_item(FUNC_START, 8'h5A);
    tick_for(6);
    drain();

    // random phases, idling pattern changes every third phase
    for (int p = 0; p < RandomPhases; p++) begin
      case (p / 3)
        0: begin tx_idle_pct = 18; rx_idle_pct = 87; end
        1: begin tx_idle_pct = 87; rx_idle_pct = 18; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      plan_phase(p);
      program_regs();
      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(0, 99) < StartPct)
          drive_item(FUNC_START, 8'($urandom_range(0, 255)));
        else
          drive_item(FUNC_TICK, 8'($urandom_range(0, 255)));
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_multitone_nibble_burst_transmitter_unit: done, clean");
    else
      $display("tb_multitone_nibble_burst_transmitter_unit: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
src/mnbt_pkg.sv
src/mnbt_div.sv
src/mnbt_seq.sv
src/multitone_nibble_burst_transmitter_unit.sv
src/mnbt_chk.sv
tb/tone_line_checker.sv
tb/tb_multitone_nibble_burst_transmitter_unit.sv
